>>> src/tsagc_pkg.sv
// package: types, codes and fixed-point constants of the tone source with agc
`default_nettype none
package tsagc_pkg;

  localparam int TIME_BITS_DEF    = 48;
  localparam int TICK_US_DEF      = 125;
  localparam int HOLD_TIME_US_DEF = 30000;

  localparam int AMP_W   = 17;
  localparam int HZ_W    = 16;
  localparam int DRAW_W  = 7;
  localparam int VOLT_W  = 19;
  localparam int GAIN_W  = 17;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int PER_W   = 20;
  localparam int DEN_W   = 43;
  localparam int VGA_W   = 33;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int BHASK_W = 58;  // q << 20
  localparam int TGT_W   = 51;  // threshold << 32

  localparam logic [AMP_W-1:0]  AMP_FULL     = 17'd65536;
  localparam logic [AMP_W-1:0]  GAIN_LOW_Q16 = 17'd20709;
  localparam logic [AMP_W-1:0]  GAIN_ONE_Q16 = 17'd65536;
  localparam logic [16:0]       BIAS_V       = 17'd80609;
  localparam logic [PER_W-1:0]  US_PER_SEC   = 20'd1000000;
  localparam logic [VGA_W-1:0]  ONE_Q32      = 33'h1_0000_0000;
  localparam logic [VGA_W-1:0]  VGA_MIN_Q32  = 33'd429496730;
  localparam logic [VGA_W-1:0]  EPS_Q32      = 33'd21474836;
  localparam logic [VGA_W-1:0]  REATTACK_Q32 = 33'd4080218931;
  localparam logic [VGA_W-1:0]  DONE_Q32     = 33'd4273492460;
  localparam logic [GAIN_W-1:0] GAIN_MIN_Q16 = 17'd6554;

  localparam logic [VOLT_W-1:0] THR_RST    = 19'd52429;
  localparam logic [VOLT_W-1:0] SUPPLY_RST = 19'd216269;
  localparam logic [CFG_W-1:0]  ATTACK_RST = 32'd967300000;
  localparam logic [CFG_W-1:0]  REL_RST    = 32'd273972;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } agc_phase_t;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SUPPLY    = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_PER, S_MOD, S_Q, S_PP, S_DEN, S_SINE, S_PK1, S_PK2,
    S_TGT, S_AGC, S_APP, S_CHK, S_HOLD, S_OUT1, S_OUT2, S_OUT3
  } seq_state_t;

endpackage
`default_nettype wire

>>> src/tone_source_with_agc.sv
// top level: tone source with attack / hold / release gain control
//
// input channel (in_valid / in_ready) takes one sample tick: amplitude,
// tone_hz, gain_pin_low and noise_draw. output channel (out_valid /
// out_ready) returns one sample: out_volts, agc_mode, applied_gain.
// configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to
// be written only while no sample is in flight; the block does not enforce it.
//
// a sample passes from input transfer to out_valid through the bit-serial
// divider, one quotient bit a cycle: 20 bits for the period, TIME_BITS for
// the time modulo, 58 for the sine and 51 more plus one clamp step for the
// gain target when the peak is above threshold, and through 12 to 14
// sequencer steps around the shared multiplier. in_ready is high only in
// the idle state between samples, so a new sample is not taken before the
// last result has been registered.
// the result sits in an output register; if the receiver stalls, the next
// sample is computed up to its last step and waits there for the transfer.
// synchronous reset clears time, hold start, phase (idle), gain (1.0) and
// restores the register defaults; no output is pending after reset.
`default_nettype none
module tone_source_with_agc
  import tsagc_pkg::*;
#(
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int TICK_US      = TICK_US_DEF,
  parameter int HOLD_TIME_US = HOLD_TIME_US_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AMP_W-1:0]  amplitude,
  input  logic [HZ_W-1:0]   tone_hz,
  input  logic              gain_pin_low,
  input  logic [DRAW_W-1:0] noise_draw,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VOLT_W-1:0] out_volts,
  output logic [MODE_W-1:0] agc_mode,
  output logic [GAIN_W-1:0] applied_gain,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int DIV_W = (TIME_BITS > BHASK_W) ? TIME_BITS : BHASK_W;
  localparam int CNT_W = $clog2(DIV_W + 1);

  seq_state_t state, state_next, ret;
  agc_phase_t phase;

  logic [TIME_BITS-1:0] elapsed, hold_began;
  logic [VGA_W-1:0]     vga, target;
  logic [VOLT_W-1:0]    thr, supply;
  logic [CFG_W-1:0]     atk, rel;

  logic [AMP_W-1:0]  amp_r, gf_r;
  logic [DRAW_W-1:0] draw_r;
  logic signed [7:0] noise_r;
  logic [PER_W-1:0]  period, n_r;
  logic              neg_r, over_r, up_r;
  logic [37:0]       q_r;
  logic [16:0]       smag, peak;

  logic [DIV_W-1:0]  quo;
  logic [DEN_W-1:0]  rem, den;
  logic [CNT_W-1:0]  cnt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // divider step
  logic [DEN_W:0] div_sh, div_diff;
  logic           div_ge;
  assign div_sh   = {rem, quo[DIV_W-1]};
  assign div_diff = div_sh - {1'b0, den};
  assign div_ge   = div_sh >= {1'b0, den};

  logic [16:0]    peak_now;
  logic           over_now;
  logic [VGA_W-1:0] diff_atk;
  assign peak_now = prod[32:16];
  assign over_now = {2'b0, peak_now} > thr;
  assign diff_atk = (target >= vga) ? target - vga : vga - target;

  // period step helpers
  logic [PER_W:0]   twice;
  logic [5:0]       nk;
  logic [5:0]       nmag;
  assign twice = {rem[PER_W-1:0], 1'b0};
  assign nk    = (draw_r >= 7'd50) ? 6'(draw_r - 7'd50) : 6'(7'd50 - draw_r);
  // (k * 0.97617) truncated is k-1 for 1..41 and k-2 for 42..50
  assign nmag  = (nk == 6'd0) ? 6'd0 : (nk < 6'd42) ? nk - 6'd1 : nk - 6'd2;

  logic [VGA_W-1:0] vga_up, vga_dn;
  assign vga_up = vga + {1'b0, prod[63:32]};
  assign vga_dn = vga - {1'b0, prod[63:32]};

  logic [TIME_BITS-1:0] hold_span;
  assign hold_span = elapsed - hold_began;

  logic signed [20:0] v_sum;
  assign v_sum = $signed({4'b0, BIAS_V})
               + (neg_r ? -$signed({4'b0, prod[48:32]}) : $signed({4'b0, prod[48:32]}))
               + 21'(noise_r);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_DIV;
      end
      S_DIV:  if (cnt == CNT_W'(1)) state_next = ret;
      S_PER:  state_next = S_DIV;
      S_MOD:  state_next = S_Q;
      S_Q: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(period - n_r);
        state_next = S_PP;
      end
      S_PP: begin
        mul_a = MUL_W'(period);
        mul_b = MUL_W'(period);
        state_next = S_DEN;
      end
      S_DEN:  state_next = S_DIV;
      S_SINE: begin
        mul_a = MUL_W'(amp_r);
        mul_b = MUL_W'(gf_r);
        state_next = S_PK1;
      end
      S_PK1: begin
        mul_a = MUL_W'(prod[32:16]);
        mul_b = MUL_W'(BIAS_V);
        state_next = S_PK2;
      end
      S_PK2:  state_next = over_now ? S_DIV : S_AGC;
      S_TGT:  state_next = S_AGC;
      S_AGC: begin
        unique case (phase)
          PH_IDLE: state_next = S_OUT1;
          PH_ATTACK: begin
            mul_a = diff_atk;
            mul_b = MUL_W'(atk);
            state_next = S_APP;
          end
          PH_HOLD: begin
            mul_a = vga;
            mul_b = REATTACK_Q32;
            state_next = S_HOLD;
          end
          default: begin
            if (over_r) begin
              state_next = S_OUT1;
            end else begin
              mul_a = ONE_Q32 - vga;
              mul_b = MUL_W'(rel);
              state_next = S_APP;
            end
          end
        endcase
      end
      S_APP:  state_next = S_CHK;
      S_CHK:  state_next = S_OUT1;
      S_HOLD: state_next = S_OUT1;
      S_OUT1: begin
        mul_a = MUL_W'(peak);
        mul_b = vga;
        state_next = S_OUT2;
      end
      S_OUT2: begin
        mul_a = prod[48:16];
        mul_b = MUL_W'(smag);
        state_next = S_OUT3;
      end
      S_OUT3: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // shared multiplier, registered; holds the output product while the result waits
  always_ff @(posedge clk) begin
    if (state != S_OUT3) prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RST;
      supply <= SUPPLY_RST;
      atk    <= ATTACK_RST;
      rel    <= REL_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: thr    <= cfg_data[VOLT_W-1:0];
        REG_SUPPLY:    supply <= cfg_data[VOLT_W-1:0];
        REG_ATTACK:    atk    <= cfg_data;
        REG_RELEASE:   rel    <= cfg_data;
        default: ;
      endcase
    end
  end

  // gain loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      hold_began <= '0;
      vga        <= ONE_Q32;
      phase      <= PH_IDLE;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT3 && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) elapsed <= elapsed + TIME_BITS'(TICK_US);
        S_AGC: begin
          if (phase == PH_IDLE && over_r) phase <= PH_ATTACK;
          if (phase == PH_RELEASE && over_r) phase <= PH_ATTACK;
        end
        S_APP: vga <= up_r ? vga_up : vga_dn;
        S_CHK: begin
          if (phase == PH_ATTACK) begin
            if (diff_atk < EPS_Q32) begin
              vga        <= target;
              phase      <= PH_HOLD;
              hold_began <= elapsed;
            end
          end else if (vga > DONE_Q32) begin
            vga   <= ONE_Q32;
            phase <= PH_IDLE;
          end
        end
        S_HOLD: begin
          if ({1'b0, target} < prod[65:32]) begin
            phase <= PH_ATTACK;
          end else if (hold_span >= TIME_BITS'(HOLD_TIME_US)) begin
            phase <= over_r ? PH_HOLD : PH_RELEASE;
          end
        end
        default: ;
      endcase
    end
  end

  // sample datapath and divider
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        amp_r  <= (amplitude > AMP_FULL) ? AMP_FULL : amplitude;
        gf_r   <= gain_pin_low ? GAIN_LOW_Q16 : GAIN_ONE_Q16;
        draw_r <= (noise_draw >= 7'd100) ? noise_draw - 7'd100 : noise_draw;
        quo    <= DIV_W'(US_PER_SEC) << (DIV_W - PER_W);
        rem    <= '0;
        den    <= DEN_W'(tone_hz == '0 ? HZ_W'(1) : tone_hz);
        cnt    <= CNT_W'(PER_W);
        ret    <= S_PER;
      end
      S_DIV: begin
        rem <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], div_ge};
        cnt <= cnt - CNT_W'(1);
      end
      S_PER: begin
        period  <= quo[PER_W-1:0];
        noise_r <= (draw_r >= 7'd50) ? $signed({2'b0, nmag}) : -$signed({2'b0, nmag});
        quo     <= DIV_W'(elapsed) << (DIV_W - TIME_BITS);
        rem     <= '0;
        den     <= DEN_W'(quo[PER_W-1:0]);
        cnt     <= CNT_W'(TIME_BITS);
        ret     <= S_MOD;
      end
      S_MOD: begin
        neg_r <= twice > {1'b0, period};
        n_r   <= (twice > {1'b0, period}) ? PER_W'(twice - {1'b0, period})
                                          : PER_W'(twice);
      end
      S_PP: q_r <= prod[37:0];
      S_DEN: begin
        // 5 p^2 - 4 q, the Bhaskara denominator
        den <= DEN_W'({prod[39:0], 2'b00}) + DEN_W'(prod[39:0])
             - DEN_W'({q_r, 2'b00});
        quo <= DIV_W'({q_r, 20'd0}) << (DIV_W - BHASK_W);
        rem <= '0;
        cnt <= CNT_W'(BHASK_W);
        ret <= S_SINE;
      end
      S_SINE: smag <= quo[16:0];
      S_PK2: begin
        peak   <= peak_now;
        over_r <= over_now;
        target <= ONE_Q32;
        quo    <= DIV_W'({thr, 32'd0}) << (DIV_W - TGT_W);
        rem    <= '0;
        den    <= DEN_W'(peak_now);
        cnt    <= CNT_W'(TGT_W);
        ret    <= S_TGT;
      end
      S_TGT: begin
        target <= ({1'b0, quo[31:0]} < VGA_MIN_Q32) ? VGA_MIN_Q32 : {1'b0, quo[31:0]};
      end
      S_AGC: up_r <= (phase == PH_RELEASE) ? 1'b1 : (target >= vga);
      S_OUT3: begin
        if (out_free) begin
          if (v_sum < 0)
            out_volts <= '0;
          else if (v_sum > $signed({2'b0, supply}))
            out_volts <= supply;
          else
            out_volts <= v_sum[VOLT_W-1:0];
          agc_mode     <= phase;
          applied_gain <= GAIN_W'((VGA_W + 1)'(vga) + (VGA_W + 1)'(32768) >> 16);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/tsagc_checker.sv
// checker: port-level properties of the tone source with agc, and its bind
`default_nettype none
module tsagc_checker
  import tsagc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VOLT_W-1:0] out_volts,
  input logic [MODE_W-1:0] agc_mode,
  input logic [GAIN_W-1:0] applied_gain
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_volts) && $stable(applied_gain))
    else $error("stalled result changed");

  // one sample at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after input transfer");

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> applied_gain >= GAIN_MIN_Q16 && applied_gain <= GAIN_ONE_Q16)
    else $error("gain out of range");

  // idle is only reached with the gain back at unity
  a_idle_unity: assert property (@(posedge clk) disable iff (rst)
    out_valid && agc_mode == PH_IDLE |-> applied_gain == GAIN_ONE_Q16)
    else $error("idle with gain not unity");

endmodule

bind tone_source_with_agc tsagc_checker u_tsagc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_volts    (out_volts),
  .agc_mode     (agc_mode),
  .applied_gain (applied_gain)
);
`default_nettype wire
